### hw/rtl/rrhs_pkg.sv
// ----------------------------------------------------------------------------
// rrhs_pkg
// Shared types and constants for the rotated rectangle history smoother.
// ----------------------------------------------------------------------------
package rrhs_pkg;

  // Default build sizes
  localparam int DEFAULT_HISTORY_DEPTH = 8;
  localparam int DEFAULT_TRACK_COUNT   = 4;

  // Newest-sample weight after reset (Q0.16, about 0.6)
  localparam logic [15:0] WEIGHT_RESET = 16'd39322;

  // Field geometry
  localparam int NUM_FIELDS = 5;
  localparam int VAL_W      = 16;
  localparam int TILT_W     = 14;
  localparam int ROW_W      = 4 * VAL_W + TILT_W;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Commands carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Field indices used by the sequencer
  localparam logic [2:0] FLD_X      = 3'd0;
  localparam logic [2:0] FLD_Y      = 3'd1;
  localparam logic [2:0] FLD_WIDTH  = 3'd2;
  localparam logic [2:0] FLD_HEIGHT = 3'd3;
  localparam logic [2:0] FLD_TILT   = 3'd4;

  // One rectangle; x sits in the lowest bits
  typedef struct packed {
    logic [TILT_W-1:0] tilt;
    logic [VAL_W-1:0]  height;
    logic [VAL_W-1:0]  width;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  x;
  } rect_t;

endpackage

### hw/rtl/rotated_rect_history_smoother_unit.sv
// ----------------------------------------------------------------------------
// rotated_rect_history_smoother_unit
// Per-track weighted moving average of rotated rectangles over a ring history.
// ----------------------------------------------------------------------------
// Sequence: a sample sums its older window entries, then for each field does
//   3 multiplies, 1 add and 16 divide steps, then loads the output register;
//   a lone entry goes straight to the output; a clear or unused slot ends in idle.
// Throughput: one item at a time; one shared 32 x SUMW multiplier and a
//   radix-2 divider set the rate. The output register frees the input early.
// Reset (rst, synchronous): all histories empty, weight back to 39322.
module rotated_rect_history_smoother_unit
  import rrhs_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH,
  parameter int TRACK_COUNT   = DEFAULT_TRACK_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Config: newest-sample weight, Q0.16
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // track_slot[1:0], center_x, center_y,
                                            // box_width, box_height, tilt[79:66]
  input  logic [0:0]             s_tuser,   // command
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // smooth_x, smooth_y, smooth_width,
                                            // smooth_height, smooth_tilt[77:64], pad
);

  // Derived widths
  localparam int IW   = $clog2(HISTORY_DEPTH);        // ring index
  localparam int MW   = $clog2(HISTORY_DEPTH);        // divisor n-1
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);    // entry count
  localparam int TW   = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
  localparam int AW   = $clog2(TRACK_COUNT * HISTORY_DEPTH);
  localparam int SUMW = VAL_W + CW;
  localparam int PW   = 32 + SUMW;
  localparam int DEPTH_ALL = TRACK_COUNT * HISTORY_DEPTH;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SUM    = 3'd1;
  localparam logic [2:0] ST_MUL_WV = 3'd2;
  localparam logic [2:0] ST_MUL_M  = 3'd3;
  localparam logic [2:0] ST_MUL_S  = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]      state;
  logic [15:0]     weight;
  logic [CW-1:0]   entry_count [TRACK_COUNT];
  logic [IW-1:0]   write_slot  [TRACK_COUNT];

  rect_t           cur_rect;
  logic [TW-1:0]   cur_slot;
  logic [IW-1:0]   cur_pos;
  logic [CW-1:0]   cur_n;
  logic [CW-1:0]   rd_idx;
  logic            rd_vld;
  logic [IW-1:0]   rd_pos;
  rect_t           rd_data;
  logic [SUMW-1:0] acc [NUM_FIELDS];
  logic [2:0]      fld;
  logic [PW-1:0]   prod;
  logic [PW-1:0]   num;
  logic [MW-1:0]   rem;
  logic [15:0]     quot;
  logic [3:0]      step;
  logic [15:0]     res [NUM_FIELDS];

  rect_t           mem [DEPTH_ALL];

  // Input decode
  logic            accept;
  logic [TW-1:0]   in_slot;
  logic            in_slot_ok;
  logic [CW-1:0]   in_count;
  logic [IW-1:0]   in_pos;
  logic [CW-1:0]   n_next;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  logic            mem_re;
  logic [AW-1:0]   rd_addr;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_slot    = TW'(s_tdata[1:0]);
  assign in_slot_ok = (int'(s_tdata[1:0]) < TRACK_COUNT);
  assign in_count   = entry_count[in_slot];
  assign in_pos     = write_slot[in_slot];
  assign n_next     = (in_count < CW'(HISTORY_DEPTH)) ? in_count + CW'(1) : in_count;
  assign mem_we     = accept && in_slot_ok && (s_tuser[0] == CMD_SAMPLE);
  assign wr_addr    = AW'(int'(in_slot) * HISTORY_DEPTH + int'(in_pos));
  assign mem_re     = (state == ST_SUM) && (rd_idx < cur_n);
  assign rd_addr    = AW'(int'(cur_slot) * HISTORY_DEPTH + int'(rd_idx[IW-1:0]));

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= rect_t'(s_tdata[ROW_W+1:2]);
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Operand selection for the shared multiplier
  logic [VAL_W-1:0] cur_val;
  logic [MW-1:0]    divisor;
  logic [16:0]      weight_c;
  logic [31:0]      mul_a;
  logic [SUMW-1:0]  mul_b;
  logic [PW-1:0]    mul_p;
  logic [PW-1:0]    num_sum;

  always_comb begin
    case (fld)
      FLD_X:      cur_val = cur_rect.x;
      FLD_Y:      cur_val = cur_rect.y;
      FLD_WIDTH:  cur_val = cur_rect.width;
      FLD_HEIGHT: cur_val = cur_rect.height;
      FLD_TILT:   cur_val = VAL_W'(cur_rect.tilt);
      default:    cur_val = '0;
    endcase
  end

  assign divisor  = MW'(cur_n - CW'(1));
  assign weight_c = 17'h10000 - {1'b0, weight};

  always_comb begin
    case (state)
      ST_MUL_WV: begin
        mul_a = 32'(cur_val);
        mul_b = SUMW'(weight);
      end
      ST_MUL_M: begin
        mul_a = prod[31:0];
        mul_b = SUMW'(divisor);
      end
      ST_MUL_S: begin
        mul_a = 32'(weight_c);
        mul_b = acc[fld];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign num_sum = num + prod;

  // One restoring divide step
  logic [MW:0]   trial;
  logic          q_bit;
  logic [MW:0]   trial_sub;
  logic [15:0]   quot_next;

  assign trial     = {rem, quot[15]};
  assign q_bit     = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};
  assign quot_next = {quot[14:0], q_bit};

  // Result packing
  rect_t out_rect;
  always_comb begin
    if (cur_n == CW'(1)) begin
      out_rect = cur_rect;
    end else begin
      out_rect.x      = res[FLD_X];
      out_rect.y      = res[FLD_Y];
      out_rect.width  = res[FLD_WIDTH];
      out_rect.height = res[FLD_HEIGHT];
      out_rect.tilt   = res[FLD_TILT][TILT_W-1:0];
    end
  end

  // Control: sequencer, counts, weight, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      weight   <= WEIGHT_RESET;
      m_tvalid <= 1'b0;
      rd_vld   <= 1'b0;
      rd_idx   <= '0;
      fld      <= '0;
      step     <= '0;
      for (int t = 0; t < TRACK_COUNT; t++) begin
        entry_count[t] <= '0;
        write_slot[t]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        weight <= cfg_wr_data;
      end
      // Output drained; a result loaded in ST_OUT sets valid instead
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      rd_vld <= mem_re;
      case (state)
        ST_IDLE: begin
          if (accept && in_slot_ok) begin
            if (s_tuser[0] == CMD_CLEAR) begin
              entry_count[in_slot] <= '0;
              write_slot[in_slot]  <= '0;
            end else begin
              entry_count[in_slot] <= n_next;
              write_slot[in_slot]  <= (int'(in_pos) == HISTORY_DEPTH - 1) ?
                                      '0 : in_pos + IW'(1);
              rd_idx <= '0;
              fld    <= FLD_X;
              state  <= (n_next == CW'(1)) ? ST_OUT : ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (mem_re) begin
            rd_idx <= rd_idx + CW'(1);
          end else if (!rd_vld) begin
            state <= ST_MUL_WV;
          end
        end
        ST_MUL_WV: state <= ST_MUL_M;
        ST_MUL_M:  state <= ST_MUL_S;
        ST_MUL_S:  state <= ST_ADD;
        ST_ADD: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            if (fld == FLD_TILT) begin
              state <= ST_OUT;
            end else begin
              fld   <= fld + 3'd1;
              state <= ST_MUL_WV;
            end
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_rect <= rect_t'(s_tdata[ROW_W+1:2]);
        cur_slot <= in_slot;
        cur_pos  <= in_pos;
        cur_n    <= n_next;
        for (int f = 0; f < NUM_FIELDS; f++) begin
          acc[f] <= '0;
        end
      end
      ST_SUM: begin
        rd_pos <= rd_idx[IW-1:0];
        // Older entries only: the slot just written is skipped
        if (rd_vld && (rd_pos != cur_pos)) begin
          acc[FLD_X]      <= acc[FLD_X]      + SUMW'(rd_data.x);
          acc[FLD_Y]      <= acc[FLD_Y]      + SUMW'(rd_data.y);
          acc[FLD_WIDTH]  <= acc[FLD_WIDTH]  + SUMW'(rd_data.width);
          acc[FLD_HEIGHT] <= acc[FLD_HEIGHT] + SUMW'(rd_data.height);
          acc[FLD_TILT]   <= acc[FLD_TILT]   + SUMW'(rd_data.tilt);
        end
      end
      ST_MUL_WV: prod <= mul_p;
      ST_MUL_M:  num  <= mul_p;
      ST_MUL_S:  prod <= mul_p;
      ST_ADD: begin
        // Drop the Q0.16 scale; the high part is already below the divisor
        quot <= num_sum[31:16];
        rem  <= num_sum[32 +: MW];
      end
      ST_DIV: begin
        rem  <= q_bit ? trial_sub[MW-1:0] : trial[MW-1:0];
        quot <= quot_next;
        if (step == 4'd15) begin
          res[fld] <= quot_next;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {(OUT_TDATA_W - ROW_W)'(0), out_rect};
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/rrhs_checker.sv
// ----------------------------------------------------------------------------
// rrhs_checker
// Port-level assertions for the rotated rectangle history smoother.
// ----------------------------------------------------------------------------
module rrhs_checker
  import rrhs_pkg::*;
#(
  parameter int TRACK_COUNT = DEFAULT_TRACK_COUNT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,   // track_slot, x, y, width, height, tilt
  input logic [0:0]             s_tuser,   // command
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata    // x, y, width, height, tilt, pad
);

  logic in_acc;
  logic slot_ok;

  assign in_acc  = s_tvalid && s_tready;
  assign slot_ok = (int'(s_tdata[1:0]) < TRACK_COUNT);

  // Stalled output transaction keeps valid and data
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output data changed while stalled");

  // A sample on a live slot occupies the unit
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && slot_ok && (s_tuser[0] == CMD_SAMPLE) |=> !s_tready)
    else $error("unit took a new transaction while a sample was in work");

  // Clear commands and unused slots finish at once
  a_clear_quick: assert property (@(posedge clk) disable iff (rst)
    in_acc && (!slot_ok || (s_tuser[0] == CMD_CLEAR)) |=> s_tready)
    else $error("clear or unused slot stalled the input");

  // Padding above the packed result is zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_TDATA_W-1:ROW_W] == '0))
    else $error("output padding not zero");

endmodule

bind rotated_rect_history_smoother_unit rrhs_checker #(
  .TRACK_COUNT(TRACK_COUNT)
) u_rrhs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
